### rtl/c2p_pkg.sv
// shared constants, payload types and arc table for the cartesian to polar converter
package c2p_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int ROTATION_STEPS = 18;
    localparam int ANGLE_WIDTH    = 16;

    localparam int ARC_ENTRIES = 32;
    localparam int NUM_ROT     = (ROTATION_STEPS < ARC_ENTRIES) ? ROTATION_STEPS : ARC_ENTRIES;
    localparam int NUM_CELLS   = (NUM_ROT > COORD_WIDTH) ? NUM_ROT : COORD_WIDTH;
    localparam int STEP_W      = $clog2(ARC_ENTRIES);

    // rotation datapath: magnitude shifted up so the word always spans 61 bits
    localparam int FRAC_BITS = 61 - COORD_WIDTH;
    localparam int DATA_W    = 64;
    localparam int ZW        = 34;

    // square root datapath
    localparam int REM_W = COORD_WIDTH + 3;
    localparam int RAD_W = 2 * COORD_WIDTH;

    // angle scale inside the chain: pi = 2^31
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sh0_8000_0000;
    localparam int                   ANGLE_LSB    = 32 - ANGLE_WIDTH;
    localparam logic signed [ZW-1:0] ROUND_HALF   = 34'sh0_0000_8000;

    // atan(2^-i) with pi = 2^31
    localparam logic [31:0] ARC_TABLE [ARC_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } point_t;

    typedef struct packed {
        logic        [COORD_WIDTH-1:0] magnitude;
        logic signed [ANGLE_WIDTH-1:0] angle;
    } polar_t;

    // quadrant and axis flags that ride alongside the chain
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic ax_zero;
        logic ay_zero;
    } side_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cx;
        logic signed [DATA_W-1:0] cy;
        logic signed [ZW-1:0]     z;
    } rot_t;

    typedef struct packed {
        logic [REM_W-1:0]       rem;
        logic [COORD_WIDTH-1:0] root;
        logic [RAD_W-1:0]       rad;
    } root_t;

endpackage

### rtl/c2p_rot_cell.sv
// one vectoring micro-rotation stage of the angle chain
module c2p_rot_cell (
    input  logic                       clk,
    input  logic                       load,
    input  logic [c2p_pkg::STEP_W-1:0] step,
    input  c2p_pkg::rot_t              rot_in,
    output c2p_pkg::rot_t              rot_out
);

    localparam int DATA_W = c2p_pkg::DATA_W;
    localparam int ZW     = c2p_pkg::ZW;

    c2p_pkg::rot_t            rot_reg;
    c2p_pkg::rot_t            rot_next;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [ZW-1:0]     arc;

    always_comb
    begin
        dx  = rot_in.cy >>> step;
        dy  = rot_in.cx >>> step;
        arc = $signed({{(ZW-32){1'b0}}, c2p_pkg::ARC_TABLE[step]});
        if (int'(step) >= c2p_pkg::NUM_ROT)
        begin
            // padding cell past the last rotation
            rot_next = rot_in;
        end
        else if (!rot_in.cy[DATA_W-1])
        begin
            rot_next.cx = rot_in.cx + dx;
            rot_next.cy = rot_in.cy - dy;
            rot_next.z  = rot_in.z + arc;
        end
        else
        begin
            rot_next.cx = rot_in.cx - dx;
            rot_next.cy = rot_in.cy + dy;
            rot_next.z  = rot_in.z - arc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot_out = rot_reg;

endmodule

### rtl/c2p_root_cell.sv
// one digit stage of the restoring integer square root chain
module c2p_root_cell (
    input  logic                       clk,
    input  logic                       load,
    input  logic [c2p_pkg::STEP_W-1:0] step,
    input  c2p_pkg::root_t             root_in,
    output c2p_pkg::root_t             root_out
);

    localparam int W     = c2p_pkg::COORD_WIDTH;
    localparam int REM_W = c2p_pkg::REM_W;
    localparam int RAD_W = c2p_pkg::RAD_W;

    c2p_pkg::root_t   root_reg;
    c2p_pkg::root_t   root_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        // bring down the next two radicand bits
        rem_sh = {root_in.rem[REM_W-3:0], root_in.rad[RAD_W-1 -: 2]};
        trial  = {1'b0, root_in.root, 2'b01};
        if (int'(step) >= W)
        begin
            root_next = root_in;
        end
        else if (rem_sh >= trial)
        begin
            root_next.rem  = rem_sh - trial;
            root_next.root = {root_in.root[W-2:0], 1'b1};
            root_next.rad  = {root_in.rad[RAD_W-3:0], 2'b00};
        end
        else
        begin
            root_next.rem  = rem_sh;
            root_next.root = {root_in.root[W-2:0], 1'b0};
            root_next.rad  = {root_in.rad[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            root_reg <= root_next;
        end
    end

    assign root_out = root_reg;

endmodule

### rtl/cartesian_to_polar.sv
// top level: pipelined cartesian to polar converter built from rotation and root cells
//
// point channel: point_valid / point_stall carry one (x_coord, y_coord) pair per
// transfer. polar channel: polar_valid / polar_stall carry one (magnitude, angle)
// result per transfer, in the order the points came in.
// the datapath is a row of NUM_CELLS+4 register stages: fold to the first quadrant,
// square, sum, then NUM_CELLS cells (each one micro-rotation next to one root digit),
// then the output register. a point's result is presented once it has passed through
// all of these stages in that order; one point enters every cycle unless point_stall is high.
// the longer of the rotation count and the root digit count sets the depth.
// angle is in binary units with pi = 32768; +pi reads as -32768.
// reset clears the stage valid bits only; the pipe then starts empty.
// while a result sits at the output with polar_stall high, every stage holds;
// the first stage still takes a new point if it is empty, so point_stall rises
// only once that stage is occupied as well.
module cartesian_to_polar (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    output logic            point_stall,
    input  c2p_pkg::point_t point,
    output logic            polar_valid,
    input  logic            polar_stall,
    output c2p_pkg::polar_t polar
);

    localparam int W      = c2p_pkg::COORD_WIDTH;
    localparam int N      = c2p_pkg::NUM_CELLS;
    localparam int P      = N + 4;
    localparam int STEP_W = c2p_pkg::STEP_W;
    localparam int DATA_W = c2p_pkg::DATA_W;
    localparam int ZW     = c2p_pkg::ZW;
    localparam int REM_W  = c2p_pkg::REM_W;
    localparam int RAD_W  = c2p_pkg::RAD_W;
    localparam int AW     = c2p_pkg::ANGLE_WIDTH;

    logic [P-1:0]    vld_reg;
    logic            adv;
    logic            en0;

    c2p_pkg::side_t  side_reg [P-1];
    c2p_pkg::side_t  side_next;
    logic [W-1:0]    ax_reg [3];
    logic [W-1:0]    ay_reg [3];
    logic [W-1:0]    ax_next;
    logic [W-1:0]    ay_next;
    logic [RAD_W-1:0] sqx_reg;
    logic [RAD_W-1:0] sqy_reg;
    logic [RAD_W-1:0] sum_reg;

    c2p_pkg::rot_t   rot_chain  [N+1];
    c2p_pkg::root_t  root_chain [N+1];

    c2p_pkg::polar_t polar_reg;
    c2p_pkg::polar_t polar_next;
    c2p_pkg::side_t  fin_side;
    logic signed [ZW-1:0] z_last;
    logic signed [ZW-1:0] base;
    logic signed [ZW-1:0] theta;
    logic signed [ZW-1:0] rounded;
    logic [W-1:0]    root_last;
    logic [REM_W-1:0] rem_last;
    logic [AW-1:0]   angle_next;

    // the whole row moves unless a result is held at the output
    assign adv         = !vld_reg[P-1] || !polar_stall;
    assign en0         = adv || !vld_reg[0];
    assign point_stall = !en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en0)
            begin
                vld_reg[0] <= point_valid;
            end
            if (adv)
            begin
                vld_reg[P-1:1] <= vld_reg[P-2:0];
            end
        end
    end

    // fold to the first quadrant
    always_comb
    begin
        ax_next = point.x_coord[W-1] ? (~point.x_coord + 1'b1) : point.x_coord;
        ay_next = point.y_coord[W-1] ? (~point.y_coord + 1'b1) : point.y_coord;
        side_next.x_neg   = point.x_coord[W-1];
        side_next.y_neg   = point.y_coord[W-1];
        side_next.ax_zero = (point.x_coord == '0);
        side_next.ay_zero = (point.y_coord == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            ax_reg[0]   <= ax_next;
            ay_reg[0]   <= ay_next;
            side_reg[0] <= side_next;
        end
        if (adv)
        begin
            sqx_reg   <= RAD_W'(ax_reg[0]) * RAD_W'(ax_reg[0]);
            sqy_reg   <= RAD_W'(ay_reg[0]) * RAD_W'(ay_reg[0]);
            sum_reg   <= sqx_reg + sqy_reg;
            ax_reg[1] <= ax_reg[0];
            ay_reg[1] <= ay_reg[0];
            ax_reg[2] <= ax_reg[1];
            ay_reg[2] <= ay_reg[1];
            for (int k = 1; k < P - 1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            polar_reg <= polar_next;
        end
    end

    always_comb
    begin
        rot_chain[0].cx  = $signed(DATA_W'(ax_reg[2]) << c2p_pkg::FRAC_BITS);
        rot_chain[0].cy  = $signed(DATA_W'(ay_reg[2]) << c2p_pkg::FRAC_BITS);
        rot_chain[0].z   = '0;
        root_chain[0].rem  = '0;
        root_chain[0].root = '0;
        root_chain[0].rad  = sum_reg;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        c2p_rot_cell u_rot (
            .clk     (clk),
            .load    (adv),
            .step    (STEP_W'(i)),
            .rot_in  (rot_chain[i]),
            .rot_out (rot_chain[i+1])
        );

        c2p_root_cell u_root (
            .clk      (clk),
            .load     (adv),
            .step     (STEP_W'(i)),
            .root_in  (root_chain[i]),
            .root_out (root_chain[i+1])
        );
    end

    // quadrant restore, axis cases and rounding into the output register
    always_comb
    begin
        fin_side  = side_reg[P-2];
        z_last    = rot_chain[N].z;
        root_last = root_chain[N].root;
        rem_last  = root_chain[N].rem;

        if (fin_side.ay_zero)
        begin
            base = '0;
        end
        else if (fin_side.ax_zero)
        begin
            base = c2p_pkg::QUARTER_TURN;
        end
        else if (z_last[ZW-1])
        begin
            base = '0;
        end
        else if (z_last > c2p_pkg::QUARTER_TURN)
        begin
            base = c2p_pkg::QUARTER_TURN;
        end
        else
        begin
            base = z_last;
        end

        if (fin_side.x_neg)
        begin
            theta = fin_side.y_neg ? (base - c2p_pkg::HALF_TURN) : (c2p_pkg::HALF_TURN - base);
        end
        else
        begin
            theta = fin_side.y_neg ? -base : base;
        end

        rounded    = theta + c2p_pkg::ROUND_HALF;
        angle_next = rounded[c2p_pkg::ANGLE_LSB +: AW];

        polar_next.angle     = $signed(angle_next);
        // round half up: remainder above the root means s >= root^2 + root + 1
        polar_next.magnitude = (rem_last > REM_W'(root_last)) ? (root_last + 1'b1) : root_last;
    end

    assign polar_valid = vld_reg[P-1];
    assign polar       = polar_reg;

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> (polar_valid && polar_stall))
        else $error("point stalled while the output is free");

    a_row_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (polar_valid && polar_stall) |=> (vld_reg[P-1:1] == $past(vld_reg[P-1:1])))
        else $error("stage valid bits moved during an output stall");

    a_origin_angle : assert property (@(posedge clk) disable iff (!rst_n)
        (polar_valid && (polar.magnitude == '0)) |-> (polar.angle == '0))
        else $error("zero magnitude with a non-zero angle");

    a_first_quadrant : assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[P-2] && !fin_side.x_neg && !fin_side.y_neg) |-> !angle_next[AW-1])
        else $error("first-quadrant point gave a negative angle");

endmodule
